// ===== src/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants for the point to segment distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int DIST_W   = 32;
  localparam int IN_W     = 32;
  localparam int NUM_AXES = 3;

endpackage

// ===== src/point_segment_distances.sv =====
// ----------------------------------------------------------------------------
// point_segment_distances
// Distance of a 3D point from a line segment, fully pipelined.
// ----------------------------------------------------------------------------
// Accepts one word per cycle. Six stages form the differences, dot
// products, the split wide products and the numerators, then a 32-stage
// unrolled bit-serial root search yields both distances, one result bit per
// stage. The whole pipeline holds, and accepts nothing, while a finished
// result is not taken. Distances are exact values truncated toward zero,
// saturating at 2^32-1, and zero when the projection is not strictly inside
// the segment.
module point_segment_distances #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [psd_pkg::IN_W-1:0]      point_x,
  input  logic [psd_pkg::IN_W-1:0]      point_y,
  input  logic [psd_pkg::IN_W-1:0]      point_z,
  input  logic [psd_pkg::IN_W-1:0]      seg_start_x,
  input  logic [psd_pkg::IN_W-1:0]      seg_start_y,
  input  logic [psd_pkg::IN_W-1:0]      seg_start_z,
  input  logic [psd_pkg::IN_W-1:0]      seg_end_x,
  input  logic [psd_pkg::IN_W-1:0]      seg_end_y,
  input  logic [psd_pkg::IN_W-1:0]      seg_end_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          on_segment,
  output logic [psd_pkg::DIST_W-1:0]    parallel_dist,
  output logic [psd_pkg::DIST_W-1:0]    perpendicular_dist
);
  import psd_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int VW    = CW + 1;
  localparam int PW    = 2 * VW;
  localparam int P     = 2 * CW + 4;
  localparam int H     = P / 2;
  localparam int REM_W = (2 * P > P + 65) ? 2 * P + 1 : P + 66;
  localparam int AW    = P + DIST_W;
  localparam int FRONT = 6;
  localparam int NST   = FRONT + DIST_W;

  logic en;
  logic [NST-1:0] vld;

  logic [IN_W-1:0]        pin [NUM_AXES];
  logic [IN_W-1:0]        sin [NUM_AXES];
  logic [IN_W-1:0]        ein [NUM_AXES];
  logic signed [CW-1:0]   pc [NUM_AXES];
  logic signed [CW-1:0]   sc [NUM_AXES];
  logic signed [CW-1:0]   ec [NUM_AXES];

  logic signed [VW-1:0]   v [NUM_AXES];
  logic signed [VW-1:0]   w [NUM_AXES];
  logic signed [PW-1:0]   pvw [NUM_AXES];
  logic signed [PW-1:0]   pvv [NUM_AXES];
  logic signed [PW-1:0]   pww [NUM_AXES];

  logic signed [P-1:0]    c1;
  logic [P-1:0]           c2, ww;
  logic [P-1:0]           c1u;

  logic                   on4, on5, on6;
  logic [P-1:0]           ma [4];
  logic [P-1:0]           mb [4];
  logic [P-1:0]           c2_4, c2_5, c2_6;
  logic [2*P-1:0]         c1sq, wwc2;
  logic [2*P-1:0]         num_p, num_x;

  assign pin = '{point_x, point_y, point_z};
  assign sin = '{seg_start_x, seg_start_y, seg_start_z};
  assign ein = '{seg_end_x, seg_end_y, seg_end_z};

  genvar a;
  generate
    for (a = 0; a < NUM_AXES; a++) begin : g_axis
      if (CW <= IN_W) begin : g_narrow
        assign pc[a] = pin[a][CW-1:0];
        assign sc[a] = sin[a][CW-1:0];
        assign ec[a] = ein[a][CW-1:0];
      end else begin : g_wide
        assign pc[a] = {{(CW-IN_W){1'b0}}, pin[a]};
        assign sc[a] = {{(CW-IN_W){1'b0}}, sin[a]};
        assign ec[a] = {{(CW-IN_W){1'b0}}, ein[a]};
      end
    end
  endgenerate

  assign en       = !vld[NST-1] || out_ready;
  assign in_ready = en;
  assign c1u      = c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        v[i]   <= $signed({ec[i][CW-1], ec[i]}) - $signed({sc[i][CW-1], sc[i]});
        w[i]   <= $signed({pc[i][CW-1], pc[i]}) - $signed({sc[i][CW-1], sc[i]});
        pvw[i] <= v[i] * w[i];
        pvv[i] <= v[i] * v[i];
        pww[i] <= w[i] * w[i];
      end
      c1 <= P'(pvw[0]) + P'(pvw[1]) + P'(pvw[2]);
      c2 <= P'(pvv[0]) + P'(pvv[1]) + P'(pvv[2]);
      ww <= P'(pww[0]) + P'(pww[1]) + P'(pww[2]);

      on4   <= (c1 > 0) && (c1 < $signed(c2));
      ma[0] <= P'(c1u[H-1:0]) * P'(c1u[H-1:0]);
      ma[1] <= P'(c1u[H-1:0]) * P'(c1u[P-1:H]);
      ma[2] <= P'(c1u[P-1:H]) * P'(c1u[H-1:0]);
      ma[3] <= P'(c1u[P-1:H]) * P'(c1u[P-1:H]);
      mb[0] <= P'(ww[H-1:0]) * P'(c2[H-1:0]);
      mb[1] <= P'(ww[H-1:0]) * P'(c2[P-1:H]);
      mb[2] <= P'(ww[P-1:H]) * P'(c2[H-1:0]);
      mb[3] <= P'(ww[P-1:H]) * P'(c2[P-1:H]);
      c2_4  <= c2;

      on5  <= on4;
      c2_5 <= c2_4;
      c1sq <= (2*P)'(ma[0]) + (((2*P)'(ma[1]) + (2*P)'(ma[2])) << H)
            + ((2*P)'(ma[3]) << (2 * H));
      wwc2 <= (2*P)'(mb[0]) + (((2*P)'(mb[1]) + (2*P)'(mb[2])) << H)
            + ((2*P)'(mb[3]) << (2 * H));

      on6   <= on5;
      c2_6  <= c2_5;
      num_p <= c1sq;
      num_x <= wwc2 - c1sq;
    end
  end

  logic [P-1:0]      den_s    [DIST_W+1];
  logic              flag_s   [DIST_W+1];
  logic [REM_W-1:0]  rem_p_s  [DIST_W+1];
  logic [AW-1:0]     acc_p_s  [DIST_W+1];
  logic [DIST_W-1:0] root_p_s [DIST_W+1];
  logic [REM_W-1:0]  rem_x_s  [DIST_W+1];
  logic [AW-1:0]     acc_x_s  [DIST_W+1];
  logic [DIST_W-1:0] root_x_s [DIST_W+1];

  assign den_s[0]    = c2_6;
  assign flag_s[0]   = on6;
  assign rem_p_s[0]  = REM_W'(num_p);
  assign acc_p_s[0]  = '0;
  assign root_p_s[0] = '0;
  assign rem_x_s[0]  = REM_W'(num_x);
  assign acc_x_s[0]  = '0;
  assign root_x_s[0] = '0;

  genvar k;
  generate
    for (k = 0; k < DIST_W; k++) begin : g_root
      psd_root_step #(
        .DEN_W (P),
        .REM_W (REM_W),
        .BIT   (DIST_W - 1 - k)
      ) u_step (
        .clk       (clk),
        .en        (en),
        .den_in    (den_s[k]),
        .flag_in   (flag_s[k]),
        .rem_p_in  (rem_p_s[k]),
        .acc_p_in  (acc_p_s[k]),
        .root_p_in (root_p_s[k]),
        .rem_x_in  (rem_x_s[k]),
        .acc_x_in  (acc_x_s[k]),
        .root_x_in (root_x_s[k]),
        .den       (den_s[k+1]),
        .flag      (flag_s[k+1]),
        .rem_p     (rem_p_s[k+1]),
        .acc_p     (acc_p_s[k+1]),
        .root_p    (root_p_s[k+1]),
        .rem_x     (rem_x_s[k+1]),
        .acc_x     (acc_x_s[k+1]),
        .root_x    (root_x_s[k+1])
      );
    end
  endgenerate

  assign out_valid          = vld[NST-1];
  assign on_segment         = flag_s[DIST_W];
  assign parallel_dist      = flag_s[DIST_W] ? root_p_s[DIST_W] : '0;
  assign perpendicular_dist = flag_s[DIST_W] ? root_x_s[DIST_W] : '0;

endmodule

// ===== src/psd_root_step.sv =====
// ----------------------------------------------------------------------------
// psd_root_step
// One registered bit step of two truncated root-of-ratio searches sharing
// one denominator: largest d with d*d*den <= num, one result bit per step.
// ----------------------------------------------------------------------------
module psd_root_step #(
  parameter int DEN_W = 68,
  parameter int REM_W = 137,
  parameter int BIT   = 31
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [DEN_W-1:0]              den_in,
  input  logic                          flag_in,
  input  logic [REM_W-1:0]              rem_p_in,
  input  logic [DEN_W+psd_pkg::DIST_W-1:0] acc_p_in,
  input  logic [psd_pkg::DIST_W-1:0]    root_p_in,
  input  logic [REM_W-1:0]              rem_x_in,
  input  logic [DEN_W+psd_pkg::DIST_W-1:0] acc_x_in,
  input  logic [psd_pkg::DIST_W-1:0]    root_x_in,
  output logic [DEN_W-1:0]              den,
  output logic                          flag,
  output logic [REM_W-1:0]              rem_p,
  output logic [DEN_W+psd_pkg::DIST_W-1:0] acc_p,
  output logic [psd_pkg::DIST_W-1:0]    root_p,
  output logic [REM_W-1:0]              rem_x,
  output logic [DEN_W+psd_pkg::DIST_W-1:0] acc_x,
  output logic [psd_pkg::DIST_W-1:0]    root_x
);
  import psd_pkg::*;

  localparam int AW = DEN_W + DIST_W;

  logic [REM_W-1:0]  sq, t_p, t_x;
  logic [AW-1:0]     inc;
  logic [DIST_W-1:0] one_bit;
  logic              take_p, take_x;

  always_comb begin
    sq      = REM_W'(den_in) << (2 * BIT);
    t_p     = (REM_W'(acc_p_in) << (BIT + 1)) + sq;
    t_x     = (REM_W'(acc_x_in) << (BIT + 1)) + sq;
    inc     = AW'(den_in) << BIT;
    one_bit = DIST_W'(1) << BIT;
    take_p  = (t_p <= rem_p_in);
    take_x  = (t_x <= rem_x_in);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den    <= den_in;
      flag   <= flag_in;
      rem_p  <= take_p ? rem_p_in - t_p : rem_p_in;
      acc_p  <= take_p ? acc_p_in + inc : acc_p_in;
      root_p <= take_p ? (root_p_in | one_bit) : root_p_in;
      rem_x  <= take_x ? rem_x_in - t_x : rem_x_in;
      acc_x  <= take_x ? acc_x_in + inc : acc_x_in;
      root_x <= take_x ? (root_x_in | one_bit) : root_x_in;
    end
  end

endmodule

// ===== sim/point_segment_distances_tb.sv =====
// ----------------------------------------------------------------------------
// point_segment_distances_tb
// Checks the point to segment distance pipeline with directed and random words.
// Each word is held to a fixed result or a bit-exact wide-integer predictor.
// Results are compared in order, with random gaps and stalls on both handshakes.
// ----------------------------------------------------------------------------
module point_segment_distances_tb;

  import psd_pkg::*;

  localparam int N_RANDOM    = 400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN       = 60;

  typedef logic [IN_W-1:0] coord_t;
  typedef coord_t          coords_t [9];

  typedef struct packed {
    logic              on;
    logic [DIST_W-1:0] par;
    logic [DIST_W-1:0] perp;
  } dist_t;

  typedef struct {
    coords_t c;
    logic    typed;
    dist_t   d;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  coord_t pin [9];
  logic out_valid;
  logic out_ready = 1'b0;
  logic on_segment;
  logic [DIST_W-1:0] parallel_dist;
  logic [DIST_W-1:0] perpendicular_dist;

  dist_t pending_dists[$];
  row_t rows[$];
  int mismatches = 0;
  int cycles = 0;

  initial foreach (pin[i]) pin[i] = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  point_segment_distances dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .point_x(pin[0]), .point_y(pin[1]), .point_z(pin[2]),
    .seg_start_x(pin[3]), .seg_start_y(pin[4]), .seg_start_z(pin[5]),
    .seg_end_x(pin[6]), .seg_end_y(pin[7]), .seg_end_z(pin[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .on_segment(on_segment), .parallel_dist(parallel_dist),
    .perpendicular_dist(perpendicular_dist)
  );

  // largest d < 2^32 with d*d*den <= num
  function automatic logic [DIST_W-1:0] trunc_root(logic [255:0] num, logic [255:0] den);
    logic [255:0] d;
    logic [255:0] cand;
    d = '0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      cand = d | (256'd1 << b);
      if (cand * cand * den <= num) d = cand;
    end
    return d[DIST_W-1:0];
  endfunction

  function automatic dist_t project_point(coords_t c);
    logic signed [255:0] p, s, e, v, w, c1, c2, ww, x;
    dist_t r;
    c1 = '0;
    c2 = '0;
    ww = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      p = $signed(c[i]);
      s = $signed(c[3+i]);
      e = $signed(c[6+i]);
      v = e - s;
      w = p - s;
      c1 = c1 + v * w;
      c2 = c2 + v * v;
      ww = ww + w * w;
    end
    r = '0;
    if (c1 > 0 && c2 > c1) begin
      x = ww * c2 - c1 * c1;
      r.on = 1'b1;
      r.par = trunc_root(c1 * c1, c2);
      r.perp = trunc_root(x, c2);
    end
    return r;
  endfunction

  function automatic void add_row(coords_t c, logic typed, dist_t d);
    row_t r;
    r.c = c;
    r.typed = typed;
    r.d = d;
    rows.insert(rows.size(), r);
  endfunction

  // drive one word, hold until accepted, queue its expected result
  task automatic send_word(coords_t c, logic typed, dist_t d);
    int gap;
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 40);
    if (gap > 0 && in_valid) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    foreach (pin[i]) pin[i] <= c[i];
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_dists.insert(pending_dists.size(), typed ? d : project_point(c));
  endtask

  always @(posedge clk) begin
    int stall;
    if (stall > 0) begin
      stall <= stall - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 9) < 2) begin
      stall <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    dist_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = {on_segment, parallel_dist, perpendicular_dist};
      if (pending_dists.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0h", got);
      end else begin
        want = pending_dists.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: on %0b/%0b par %0h/%0h perp %0h/%0h (exp/got)",
                     want.on, got.on, want.par, got.par, want.perp, got.perp);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("point_segment_distances_tb: done, errors");
      $finish;
    end
  end

  initial begin
    coords_t c;
    coord_t lo, hi;
    int k;
    lo = 32'h8000_0000;
    hi = 32'h7fff_ffff;
    add_row('{default: '0}, 1, '0);
    add_row('{32'h10000, 0, 0, 32'h5, 7, 9, 32'h5, 7, 9}, 1, '0);
    add_row('{32'h10000, 32'h10000, 0, 0, 0, 0, 32'h20000, 0, 0}, 1,
            '{1'b1, 32'h10000, 32'h10000});
    add_row('{32'h20000, 0, 0, 0, 0, 0, 32'h20000, 0, 0}, 1, '0);
    add_row('{32'hffff0000, 32'h30000, 0, 0, 0, 0, 32'h20000, 0, 0}, 1, '0);
    add_row('{0, 0, 0, lo, 0, 0, hi, 0, 0}, 0, '0);
    add_row('{hi, hi, lo, lo, lo, lo, hi, hi, hi}, 0, '0);
    add_row('{hi, lo, hi, lo, lo, lo, hi, hi, hi}, 0, '0);
    add_row('{0, hi, lo, lo, 0, 0, hi, 0, 0}, 0, '0);
    add_row('{1, 1, 1, 0, 0, 0, 2, 2, 2}, 0, '0);
    add_row('{hi, hi, hi, hi, hi, hi, lo, lo, lo}, 0, '0);
    add_row('{32'hfffffffe, hi, lo, hi, lo, hi, lo, hi, lo}, 0, '0);
    add_row('{32'hffffffff, 32'hffffffff, 32'hffffffff, hi, hi, hi,
              lo, lo, lo}, 0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[r]) send_word(rows[r].c, rows[r].typed, rows[r].d);

    for (int n = 0; n < N_RANDOM; n++) begin
      k = $urandom_range(0, 9);
      foreach (c[i])
        c[i] = (k < 3) ? $urandom() : coord_t'($signed($urandom_range(0, 2097151)) - 1048576);
      // place the point near a spot between start and end
      if (k >= 5)
        for (int i = 0; i < NUM_AXES; i++)
          c[i] = c[3+i] + ((c[6+i] - c[3+i]) >>> $urandom_range(1, 3)) +
                 coord_t'($signed($urandom_range(0, 8191)) - 4096);
      send_word(c, 0, '0);
    end
    in_valid <= 1'b0;

    while (pending_dists.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0)
      $display("point_segment_distances_tb: done, clean");
    else
      $display("point_segment_distances_tb: done, errors");
    $finish;
  end

endmodule
